>>> design/assert_macros.svh
// Assertion macros for the checked RTL; the top-level file includes them.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in a cycle implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in a cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ttf_pkg.sv
// Package of the text to 32.32 fixed-point parser: types, sizes, power-of-ten table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ttf_pkg;

    localparam int unsigned MAX_FRACTION_DIGITS = 9;
    localparam int unsigned HEX_DIGITS          = 8;
    localparam int unsigned DIV_STEPS           = 32;
    localparam int unsigned QUEUE_DEPTH         = 2;
    localparam int unsigned QPTR_W              = $clog2(QUEUE_DEPTH);
    localparam int unsigned STEP_W              = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        PH_START,
        PH_LEAD,
        PH_MINUS,
        PH_PLUS,
        PH_INT,
        PH_FRAC,
        PH_ZERO,
        PH_HEX_SP,
        PH_HEX_INT,
        PH_HEX_POINT,
        PH_HEX_FRAC,
        PH_HEX_END,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_RND,
        B_NEG
    } t_bstate;

    typedef logic [3:0]  t_fcnt;
    typedef logic [29:0] t_pow;

    typedef struct packed {
        logic        err;
        logic        neg;
        logic        dec;
        t_fcnt       fcnt;
        logic [31:0] int_val;
        logic [31:0] frac_val;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic t_pow pow_ten(input t_fcnt n);
        t_pow v;
        unique case (n)
            4'd1:    v = 30'd10;
            4'd2:    v = 30'd100;
            4'd3:    v = 30'd1000;
            4'd4:    v = 30'd10000;
            4'd5:    v = 30'd100000;
            4'd6:    v = 30'd1000000;
            4'd7:    v = 30'd10000000;
            4'd8:    v = 30'd100000000;
            4'd9:    v = 30'd1000000000;
            default: v = 30'd1;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> design/ttf_front.sv
// Front end: takes one byte per transfer, runs the parse state machine,
// pushes a finished job on the last byte. Depends on ttf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [7:0]     i_ch,
    input  logic           i_last_char,
    input  ttf_pkg::t_qstat i_qstat,
    output logic           o_push,
    output ttf_pkg::t_job  o_job
);
    import ttf_pkg::*;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D9    = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    t_phase      r_phase, n_phase;
    logic        r_neg, n_neg;
    logic        r_err, n_err;
    logic        r_dec, n_dec;
    logic [31:0] r_int, n_int;
    logic [31:0] r_frac, n_frac;
    t_fcnt       r_fcnt, n_fcnt;
    logic [3:0]  r_hcnt, n_hcnt;

    logic        accept;
    logic        c_ws, c_dec, c_term, c_hex;
    logic [3:0]  c_hval;
    logic        cont, go_hex_int, go_hex_frac;
    logic        fin_err, fin_dec;

    assign accept  = i_valid && !o_stall;
    assign o_stall = i_qstat.full;

    always_comb begin
        c_ws   = (i_ch == CH_SPACE) || (i_ch >= CH_TAB && i_ch <= CH_CR);
        c_dec  = (i_ch >= CH_D0) && (i_ch <= CH_D9);
        c_term = (i_ch == CH_NUL) || c_ws;
        c_hex  = 1'b1;
        c_hval = i_ch[3:0];
        if (c_dec) begin
            c_hval = i_ch[3:0];
        end else if ((i_ch >= CH_LA && i_ch <= CH_LF) || (i_ch >= CH_UA && i_ch <= CH_UF)) begin
            c_hval = i_ch[3:0] + 4'd9;
        end else begin
            c_hex = 1'b0;
        end
    end

    // One byte through the parse rules.
    always_comb begin
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_err       = r_err;
        n_dec       = r_dec;
        n_int       = r_int;
        n_frac      = r_frac;
        n_fcnt      = r_fcnt;
        n_hcnt      = r_hcnt;
        cont        = 1'b1;
        go_hex_int  = 1'b0;
        go_hex_frac = 1'b0;

        if (n_phase == PH_DONE) begin
            cont = 1'b0;
        end
        if (cont && n_phase == PH_START) begin
            if (i_ch == CH_D0) begin
                n_phase = PH_ZERO;
                cont    = 1'b0;
            end else begin
                n_phase = PH_LEAD;
            end
        end
        if (cont && n_phase == PH_ZERO) begin
            if (i_ch == CH_LX || i_ch == CH_UX) begin
                n_phase = PH_HEX_SP;
                cont    = 1'b0;
            end else begin
                n_phase = PH_INT;
            end
        end
        if (cont && n_phase == PH_LEAD) begin
            if (c_ws) begin
                cont = 1'b0;
            end else if (i_ch == CH_MINUS) begin
                n_neg   = 1'b1;
                n_phase = PH_MINUS;
                cont    = 1'b0;
            end else if (i_ch == CH_PLUS) begin
                n_phase = PH_PLUS;
                cont    = 1'b0;
            end
        end else if (cont && n_phase == PH_MINUS) begin
            if (i_ch == CH_PLUS) begin
                n_phase = PH_PLUS;
                cont    = 1'b0;
            end
        end
        if (cont && (n_phase == PH_LEAD || n_phase == PH_MINUS || n_phase == PH_PLUS)) begin
            if (c_dec) begin
                n_phase = PH_INT;
            end else if (i_ch == CH_DOT) begin
                n_phase = PH_FRAC;
                cont    = 1'b0;
            end else begin
                n_err   = 1'b1;
                n_phase = PH_DONE;
                cont    = 1'b0;
            end
        end
        if (cont) begin
            unique case (n_phase)
                PH_INT: begin
                    if (c_dec) begin
                        n_int = {r_int[28:0], 3'b000} + {r_int[30:0], 1'b0} + {28'd0, i_ch[3:0]};
                    end else if (i_ch == CH_DOT) begin
                        n_phase = PH_FRAC;
                    end else if (c_term) begin
                        n_dec   = 1'b1;
                        n_phase = PH_DONE;
                    end else begin
                        n_err   = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
                PH_FRAC: begin
                    if (c_dec) begin
                        if (r_fcnt < t_fcnt'(MAX_FRACTION_DIGITS)) begin
                            n_frac = {r_frac[28:0], 3'b000} + {r_frac[30:0], 1'b0}
                                   + {28'd0, i_ch[3:0]};
                            n_fcnt = r_fcnt + t_fcnt'(1);
                        end
                    end else if (c_term) begin
                        n_dec   = 1'b1;
                        n_phase = PH_DONE;
                    end else begin
                        n_err   = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
                PH_HEX_SP: begin
                    if (!c_ws) begin
                        n_phase    = PH_HEX_INT;
                        go_hex_int = 1'b1;
                    end
                end
                PH_HEX_INT: begin
                    go_hex_int = 1'b1;
                end
                PH_HEX_POINT: begin
                    n_phase = PH_HEX_FRAC;
                    if (i_ch != CH_DOT) begin
                        go_hex_frac = 1'b1;
                    end
                end
                PH_HEX_FRAC: begin
                    go_hex_frac = 1'b1;
                end
                PH_HEX_END: begin
                    if (c_term) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_err   = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    n_err   = 1'b1;
                    n_phase = PH_DONE;
                end
            endcase
        end
        if (go_hex_int || go_hex_frac) begin
            if (!c_hex) begin
                n_err   = 1'b1;
                n_phase = PH_DONE;
            end else begin
                n_hcnt = r_hcnt + 4'd1;
                if (go_hex_int) begin
                    n_int = {r_int[27:0], c_hval};
                    if (n_hcnt >= 4'(HEX_DIGITS)) begin
                        n_hcnt  = 4'd0;
                        n_phase = PH_HEX_POINT;
                    end
                end else begin
                    n_frac = {r_frac[27:0], c_hval};
                    if (n_hcnt >= 4'(HEX_DIGITS)) begin
                        n_phase = PH_HEX_END;
                    end
                end
            end
        end
    end

    // End of string acts as a NUL after the last byte.
    always_comb begin
        fin_err = n_err;
        fin_dec = n_dec;
        unique case (n_phase)
            PH_ZERO, PH_INT, PH_FRAC: fin_dec = 1'b1;
            PH_HEX_END, PH_DONE:      fin_dec = n_dec;
            default:                  fin_err = 1'b1;
        endcase
    end

    assign o_push         = accept && i_last_char;
    assign o_job.err      = fin_err;
    assign o_job.neg      = n_neg;
    assign o_job.dec      = fin_dec;
    assign o_job.fcnt     = n_fcnt;
    assign o_job.int_val  = n_int;
    assign o_job.frac_val = n_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last_char)) begin
            r_phase <= PH_START;
            r_neg   <= 1'b0;
            r_err   <= 1'b0;
            r_dec   <= 1'b0;
            r_int   <= '0;
            r_frac  <= '0;
            r_fcnt  <= '0;
            r_hcnt  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_err   <= n_err;
            r_dec   <= n_dec;
            r_int   <= n_int;
            r_frac  <= n_frac;
            r_fcnt  <= n_fcnt;
            r_hcnt  <= n_hcnt;
        end
    end

endmodule

`default_nettype wire

>>> design/ttf_queue.sv
// Short job queue between the parse front end and the conversion back end.
// Depends on ttf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ttf_pkg::t_job   i_job,
    input  logic            i_pop,
    output ttf_pkg::t_job   o_job,
    output ttf_pkg::t_qstat o_qstat
);
    import ttf_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_job         = r_mem[r_rd];
    assign o_qstat.full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/ttf_back.sv
// Back end: restoring fraction division, rounding, sign, output register.
// Depends on ttf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ttf_pkg::t_qstat i_qstat,
    input  ttf_pkg::t_job   i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_status,
    output logic [31:0]     o_integer_part,
    output logic [31:0]     o_fraction_part
);
    import ttf_pkg::*;

    t_bstate           r_state, n_state;
    logic              r_err, n_err;
    logic              r_neg, n_neg;
    logic              r_dec, n_dec;
    logic [31:0]       r_int, n_int;
    logic [31:0]       r_frac, n_frac;
    logic [29:0]       r_rem, n_rem;
    logic [31:0]       r_q, n_q;
    t_pow              r_tf, n_tf;
    logic [STEP_W-1:0] r_step, n_step;

    logic              r_ovalid;
    logic              r_ostatus;
    logic [31:0]       r_oint, r_ofrac;

    logic              job_div, last_step, out_free, load_out;
    logic [30:0]       w_shift, w_sub;
    logic              w_ge, w_round;
    logic [63:0]       w_negv;

    assign job_div   = !i_job.err && i_job.dec && (i_job.fcnt != '0);
    assign last_step = (r_step == STEP_W'(DIV_STEPS - 1));
    assign out_free  = !r_ovalid || !i_stall;
    assign o_pop     = (r_state == B_IDLE) && !i_qstat.empty;
    assign load_out  = (r_state == B_NEG) && out_free;

    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = (w_shift >= {1'b0, r_tf});
    assign w_sub   = w_shift - {1'b0, r_tf};
    assign w_round = (w_shift > {1'b0, r_tf});
    assign w_negv  = ~{r_int, r_frac} + 64'd1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = job_div ? B_DIV : B_NEG;
                end
            end
            B_DIV: begin
                if (last_step) begin
                    n_state = B_RND;
                end
            end
            B_RND: n_state = B_NEG;
            B_NEG: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        n_err  = r_err;
        n_neg  = r_neg;
        n_dec  = r_dec;
        n_int  = r_int;
        n_frac = r_frac;
        n_rem  = r_rem;
        n_q    = r_q;
        n_tf   = r_tf;
        n_step = r_step;
        unique case (r_state)
            B_IDLE: begin
                n_err  = i_job.err;
                n_neg  = i_job.neg;
                n_dec  = i_job.dec;
                n_int  = i_job.int_val;
                n_frac = i_job.frac_val;
                n_rem  = i_job.frac_val[29:0];
                n_q    = '0;
                n_tf   = pow_ten(i_job.fcnt);
                n_step = '0;
            end
            B_DIV: begin
                n_rem  = w_ge ? w_sub[29:0] : w_shift[29:0];
                n_q    = {r_q[30:0], w_ge};
                n_step = r_step + STEP_W'(1);
            end
            B_RND: begin
                n_frac = r_q + {31'd0, w_round};
            end
            B_NEG: begin
                n_err = r_err;
            end
            default: n_err = r_err;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err  <= n_err;
        r_neg  <= n_neg;
        r_dec  <= n_dec;
        r_int  <= n_int;
        r_frac <= n_frac;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_tf   <= n_tf;
        r_step <= n_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_ostatus <= r_err;
            if (r_err) begin
                r_oint  <= '0;
                r_ofrac <= '0;
            end else if (r_dec && r_neg) begin
                r_oint  <= w_negv[63:32];
                r_ofrac <= w_negv[31:0];
            end else begin
                r_oint  <= r_int;
                r_ofrac <= r_frac;
            end
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_integer_part  = r_oint;
    assign o_fraction_part = r_ofrac;

endmodule

`default_nettype wire

>>> design/text_to_fixed_32_32_parser.sv
// Text to 32.32 fixed-point parser, top level.
// Depends on ttf_pkg, ttf_front, ttf_queue, ttf_back and assert_macros.svh.
//
// Input channel: one ASCII byte (i_ch) per transfer, i_last_char marks the
// final byte of a string. Bytes are taken one per cycle; o_stall rises only
// while the two-entry job queue is full.
// Output channel: one result per string, o_status (1 = syntax error, value
// zero) with o_integer_part and o_fraction_part.
// After the last byte a job goes through the queue, then the back-end states
// B_IDLE and B_NEG and the output register; when a decimal fraction is
// present, the 32-step restoring divider (B_DIV) and B_RND come before B_NEG.
// Throughput: the front end takes a byte every cycle while o_stall is low;
// the back end handles one string at a time and pops the next job only in
// B_IDLE, so short decimal strings with fractions are held up by the divider.
// Reset (synchronous, active low) empties the queue, drops any pending
// result and returns the parser to the first byte of a string.
// While i_stall is high the result is held and the back end waits before
// loading the next one; the front end keeps taking bytes until the queue fills.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module text_to_fixed_32_32_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_last_char,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_status,
    output logic [31:0] o_integer_part,
    output logic [31:0] o_fraction_part
);
    import ttf_pkg::*;

    t_qstat qstat;
    t_job   push_job, pop_job;
    logic   push, pop;

    ttf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_ch        (i_ch),
        .i_last_char (i_last_char),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_job       (push_job)
    );

    ttf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_qstat (qstat)
    );

    ttf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_qstat         (qstat),
        .i_job           (pop_job),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_integer_part  (o_integer_part),
        .o_fraction_part (o_fraction_part)
    );

    `ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, push, !qstat.full, "push into full queue")
    `ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, pop, !qstat.empty, "pop from empty queue")
    `ASSERT_SAME(a_err_zero, i_clk, i_rst_n, o_valid && o_status,
        (o_integer_part == 32'd0) && (o_fraction_part == 32'd0), "error result carries a value")
    `ASSERT_NEXT(a_pop_busy, i_clk, i_rst_n, pop, !pop, "back end popped twice in a row")

endmodule

`default_nettype wire
